@@ hw/rtl/pdpr_pkg.sv @@
// Shared constants and types for the PIN digit permutation remap.
package pdpr_pkg;

    localparam int DEFAULT_NUM_DIGITS = 10;
    localparam int SEED_W             = 32;
    localparam int CHAR_W             = 8;
    localparam int MAPPED_W           = 6;
    // Digits and positions stay below 16 for any supported alphabet size
    localparam int DIGIT_W            = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 8'h39;

    typedef struct packed {
        logic               ok;     // character is a digit inside the alphabet
        logic               found;  // digit's position already resolved
        logic [DIGIT_W-1:0] digit;
        logic [DIGIT_W-1:0] pos;
    } tag_t;

endpackage

@@ hw/rtl/pdpr_decode.sv @@
// Input stage: classifies the PIN character and loads the seed into the pipe.
module pdpr_decode
    import pdpr_pkg::*;
#(
    parameter int NUM_DIGITS = DEFAULT_NUM_DIGITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CHAR_W-1:0]     pin_char,
    input  logic [SEED_W-1:0]     seed,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SEED_W-1:0]     out_v,
    output logic [NUM_DIGITS-1:0] out_used,
    output tag_t                  out_tag
);

    logic                  valid_reg;
    logic [SEED_W-1:0]     v_reg;
    tag_t                  tag_reg;
    tag_t                  tag_next;
    logic [CHAR_W-1:0]     offset;
    logic                  load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;
    assign offset   = pin_char - ASCII_ZERO;

    always_comb
    begin
        tag_next.ok    = (pin_char >= ASCII_ZERO) && (pin_char <= ASCII_NINE) &&
                         (offset < CHAR_W'(NUM_DIGITS));
        tag_next.found = 1'b0;
        tag_next.digit = offset[DIGIT_W-1:0];
        tag_next.pos   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            v_reg   <= seed;
            tag_reg <= tag_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_v     = v_reg;
    assign out_used  = '0;
    assign out_tag   = tag_reg;

endmodule

@@ hw/rtl/pdpr_step.sv @@
// One unranking step: reciprocal divide stage, then remainder and digit pick stage.
module pdpr_step
    import pdpr_pkg::*;
#(
    parameter int NUM_DIGITS = DEFAULT_NUM_DIGITS,
    parameter int STEP       = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [SEED_W-1:0]     in_v,
    input  logic [NUM_DIGITS-1:0] in_used,
    input  tag_t                  in_tag,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SEED_W-1:0]     out_v,
    output logic [NUM_DIGITS-1:0] out_used,
    output tag_t                  out_tag
);

    localparam int DIVISOR = NUM_DIGITS - STEP;
    localparam int LOG_D   = $clog2(DIVISOR);
    localparam int SHIFT   = SEED_W + LOG_D;
    // ceil(2^SHIFT / DIVISOR): exact quotient for every 32-bit dividend
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [SEED_W:0] RECIP = RECIP_FULL[SEED_W:0];
    localparam logic [NUM_DIGITS-1:0] ONE = NUM_DIGITS'(1);

    // divide stage
    logic                  valid_a_reg;
    logic [SEED_W-1:0]     v_a_reg;
    logic [SEED_W-1:0]     q_a_reg;
    logic [NUM_DIGITS-1:0] used_a_reg;
    tag_t                  tag_a_reg;
    logic                  ready_a;
    logic [2*SEED_W:0]     prod;
    logic [SEED_W-1:0]     q_next;

    // pick stage
    logic                  valid_b_reg;
    logic [SEED_W-1:0]     v_b_reg;
    logic [NUM_DIGITS-1:0] used_b_reg;
    tag_t                  tag_b_reg;
    logic                  ready_b;
    logic [SEED_W-1:0]     rem_full;
    logic [DIGIT_W-1:0]    rem;
    logic [NUM_DIGITS-1:0] sel;
    logic [NUM_DIGITS-1:0] used_next;
    tag_t                  tag_next;

    assign ready_b  = !valid_b_reg || out_ready;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    assign prod   = (2*SEED_W+1)'(in_v) * (2*SEED_W+1)'(RECIP);
    assign q_next = SEED_W'(prod >> SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end
        else if (ready_a)
        begin
            valid_a_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            v_a_reg    <= in_v;
            q_a_reg    <= q_next;
            used_a_reg <= in_used;
            tag_a_reg  <= in_tag;
        end
    end

    assign rem_full = v_a_reg - q_a_reg * SEED_W'(DIVISOR);
    assign rem      = rem_full[DIGIT_W-1:0];

    // the chosen digit is the free one with exactly rem free digits below it
    always_comb
    begin
        for (int j = 0; j < NUM_DIGITS; j++)
        begin
            sel[j] = !used_a_reg[j] &&
                     ($countones(~used_a_reg & ((ONE << j) - ONE)) == int'(rem));
        end
    end

    always_comb
    begin
        used_next = used_a_reg | sel;
        tag_next  = tag_a_reg;
        for (int j = 0; j < NUM_DIGITS; j++)
        begin
            if (sel[j] && tag_a_reg.ok && !tag_a_reg.found &&
                (tag_a_reg.digit == DIGIT_W'(j)))
            begin
                tag_next.found = 1'b1;
                tag_next.pos   = DIGIT_W'(STEP);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
        end
        else if (ready_b)
        begin
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_b && valid_a_reg)
        begin
            v_b_reg    <= q_a_reg;
            used_b_reg <= used_next;
            tag_b_reg  <= tag_next;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_v     = v_b_reg;
    assign out_used  = used_b_reg;
    assign out_tag   = tag_b_reg;

    // reciprocal quotient must leave a remainder below the divisor
    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_a_reg |-> (rem_full < SEED_W'(DIVISOR)))
        else $error("remainder out of range");

    // exactly one new digit taken per step
    a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
        valid_b_reg |-> ($countones(used_b_reg) == STEP + 1))
        else $error("used mask count wrong");

    // a stalled pick stage keeps its item
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_b_reg && !out_ready) |=> (valid_b_reg && $stable(used_b_reg) &&
                                         $stable(tag_b_reg)))
        else $error("pick stage lost item under stall");

endmodule

@@ hw/rtl/pin_digit_permutation_remap.sv @@
// Throughput: one request per cycle while the output is not stalled;
// each unranking step is a divide stage and a pick stage.
// Every stage holds its own valid bit, so bubbles close up and a stalled output holds.
// Reset: rst_n asynchronous, active low; clears all stage valid bits and grid_seed to 0.
// grid_seed is sampled by the input stage, so it may be rewritten whenever the pipe is empty.
module pin_digit_permutation_remap
    import pdpr_pkg::*;
#(
    parameter int NUM_DIGITS = DEFAULT_NUM_DIGITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SEED_W-1:0] cfg_wdata,        // grid_seed
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,     // [7:0] pin_char
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,     // [5:0] mapped_char, [7:6] zero
    output logic [0:0]        m_axis_tuser      // [0] bad_digit
);

    logic [SEED_W-1:0]     grid_seed_reg;
    logic [NUM_DIGITS:0]   valid_s;
    logic [NUM_DIGITS:0]   ready_s;
    logic [SEED_W-1:0]     v_s    [0:NUM_DIGITS];
    logic [NUM_DIGITS-1:0] used_s [0:NUM_DIGITS];
    tag_t                  tag_s  [0:NUM_DIGITS];
    tag_t                  fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_seed_reg <= '0;
        end
        else if (cfg_we)
        begin
            grid_seed_reg <= cfg_wdata;
        end
    end

    pdpr_decode #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .pin_char  (s_axis_tdata),
        .seed      (grid_seed_reg),
        .out_valid (valid_s[0]),
        .out_ready (ready_s[0]),
        .out_v     (v_s[0]),
        .out_used  (used_s[0]),
        .out_tag   (tag_s[0])
    );

    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_step
        pdpr_step #(
            .NUM_DIGITS (NUM_DIGITS),
            .STEP       (i)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_s[i]),
            .in_ready  (ready_s[i]),
            .in_v      (v_s[i]),
            .in_used   (used_s[i]),
            .in_tag    (tag_s[i]),
            .out_valid (valid_s[i+1]),
            .out_ready (ready_s[i+1]),
            .out_v     (v_s[i+1]),
            .out_used  (used_s[i+1]),
            .out_tag   (tag_s[i+1])
        );
    end

    assign fin                 = tag_s[NUM_DIGITS];
    assign ready_s[NUM_DIGITS] = m_axis_tready;
    assign m_axis_tvalid       = valid_s[NUM_DIGITS];
    assign m_axis_tdata        = fin.ok ? {2'b00, ASCII_ZERO[MAPPED_W-1:0] +
                                           MAPPED_W'(fin.pos)} : 8'h00;
    assign m_axis_tuser        = !fin.ok;

    // every valid digit gets a position once all steps have run
    a_all_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && fin.ok) |-> fin.found)
        else $error("digit position not resolved");

    // the full permutation is built by the last step
    a_perm_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (used_s[NUM_DIGITS] == {NUM_DIGITS{1'b1}}))
        else $error("permutation incomplete");

    // a result only appears after a request went in; last step is two stages deep
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(valid_s[NUM_DIGITS-1], 2) ||
                                  $past(m_axis_tvalid)))
        else $error("result without request");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for pin_digit_permutation_remap: seeded digit remapping over a stream.
module tb;
    import pdpr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DIGITS    = DEFAULT_NUM_DIGITS;
    localparam int PIPE_DEPTH  = 2 * N_DIGITS + 1;
    localparam int LONG_HOLD   = 300;
    localparam int STUCK_LIMIT = 3000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [MAPPED_W-1:0] mapped_char;
        logic                bad_digit;
    } remap_result_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [SEED_W-1:0] cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;     // [7:0] pin_char
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;     // [5:0] mapped_char, [7:6] zero
    logic [0:0]        m_axis_tuser;     // [0] bad_digit

    logic [SEED_W-1:0] seed_shadow;
    remap_result_t     pending_maps[$];
    int                mismatch_count;
    int                src_idle_pct;
    int                sink_stall_pct;
    logic              hold_req;
    int                hold_cnt;
    int                stuck_cycles;

    pin_digit_permutation_remap i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    // Position of the digit in the permutation unranked from the seed, as ASCII
    function automatic remap_result_t remap_pin_char(logic [SEED_W-1:0] seed, logic [7:0] c);
        remap_result_t res;
        logic [SEED_W-1:0] run;
        logic [15:0]       used;
        int unsigned       divisor;
        int unsigned       rem;
        int unsigned       cnt;
        int unsigned       digit;
        logic [7:0]        pos;
        res.mapped_char = '0;
        res.bad_digit   = 1'b1;
        if (c < ASCII_ZERO || c > ASCII_NINE || int'(c - ASCII_ZERO) >= N_DIGITS)
            return res;
        digit = c - ASCII_ZERO;
        run   = seed;
        used  = '0;
        pos   = '0;
        for (int i = 0; i < N_DIGITS; i++)
        begin
            divisor = N_DIGITS - i;
            rem     = run % divisor;
            run     = run / divisor;
            cnt     = 0;
            for (int j = 0; j < N_DIGITS; j++)
            begin
                if (used[j])
                    continue;
                if (cnt == rem)
                begin
                    used[j] = 1'b1;
                    if (j == digit)
                        pos = 8'(i);
                    break;
                end
                cnt++;
            end
        end
        res.mapped_char = MAPPED_W'(ASCII_ZERO + pos);
        res.bad_digit   = 1'b0;
        return res;
    endfunction

    function automatic logic [7:0] random_pin_char();
        if ($urandom_range(99) < 80)
            return ASCII_ZERO + 8'($urandom_range(9));
        return 8'($urandom_range(255));
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_pin_char(input logic [7:0] c);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = c;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_maps.insert(pending_maps.size(), remap_pin_char(seed_shadow, c));
        @(negedge clk);
    endtask

    task automatic drain_requests();
        s_axis_tvalid = 1'b0;
        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_grid_seed(input logic [SEED_W-1:0] seed);
        drain_requests();
        cfg_we      = 1'b1;
        cfg_wdata   = seed;
        seed_shadow = seed;
        @(negedge clk);
        cfg_we      = 1'b0;
    endtask

    task automatic test_reset_seed();
        logic [7:0] odd_chars[6] = '{8'h00, 8'hFF, 8'h2F, 8'h3A, 8'hB5, 8'h7F};
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int d = 0; d < 10; d++)
            send_pin_char(ASCII_ZERO + 8'(d));
        foreach (odd_chars[k])
            send_pin_char(odd_chars[k]);
    endtask

    task automatic test_full_seed();
        set_grid_seed(32'hFFFF_FFFF);
        for (int d = 9; d >= 0; d--)
            send_pin_char(ASCII_ZERO + 8'(d));
    endtask

    task automatic test_random_phase(input logic [SEED_W-1:0] seed, input int src_pct,
                                     input int sink_pct, input int count);
        set_grid_seed(seed);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int n = 0; n < count; n++)
            send_pin_char(random_pin_char());
        drain_requests();
    endtask

    // Long receiver hold-off fills the pipe, then the sender waits for a full drain
    task automatic test_backpressure();
        set_grid_seed($urandom());
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        for (int n = 0; n < 60; n++)
            send_pin_char(random_pin_char());
        s_axis_tvalid = 1'b0;
        while (pending_maps.size() != 0)
            @(posedge clk);
        @(negedge clk);
        for (int n = 0; n < 40; n++)
            send_pin_char(random_pin_char());
        drain_requests();
    endtask

    // Receiver: random stalls, or a counted hold-off when asked
    initial
    begin
        m_axis_tready = 1'b0;
        hold_cnt      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready = 1'b0;
                hold_cnt++;
                if (hold_cnt >= LONG_HOLD)
                begin
                    hold_req = 1'b0;
                    hold_cnt = 0;
                end
            end
            else
                m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        remap_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_maps.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: mapped_char=%h bad_digit=%b",
                             m_axis_tdata[5:0], m_axis_tuser[0]);
            end
            else
            begin
                want = pending_maps.pop_front();
                if (want.mapped_char !== m_axis_tdata[5:0] || want.bad_digit !== m_axis_tuser[0])
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("mismatch: mapped_char exp %h got %h, bad_digit exp %b got %b",
                                 want.mapped_char, m_axis_tdata[5:0],
                                 want.bad_digit, m_axis_tuser[0]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        seed_shadow    = '0;
        mismatch_count = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 1'b0;
        stuck_cycles   = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_seed();
        test_full_seed();
        test_random_phase(32'd3628799, 0, 0, 170);     // last rank of 10!
        test_random_phase(32'd3628800, 75, 0, 170);    // wraps to rank 0
        test_random_phase($urandom(), 0, 75, 170);
        test_random_phase(32'd1, 9, 9, 170);
        test_backpressure();

        drain_requests();
        repeat (PIPE_DEPTH + 5) @(posedge clk);
        if (pending_maps.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
